// ===== design/lis_pkg.sv =====
// Shared constants, types and helpers for the LIS length tracker.
`timescale 1ns / 1ps

package lis_pkg;

  // Store depth and element width
  localparam int MAX_LEN = 1024;
  localparam int DATA_W  = 32;

  // Derived widths: store index, tail count (holds MAX_LEN), result length field
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int LEN_W = 11;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST_CMP,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;          // capture the request and its compare read
    logic set_append;    // element goes past the last tail
    logic start_search;  // open the search window over the whole store
    logic step;          // narrow the search window by one probe
    logic update;        // write the store and load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;      // store empty
    logic cnt_one;       // store holds a single tail
    logic gt_last;       // element greater than the last tail
    logic search_done;   // search window closes on this probe
    logic out_free;      // result register can take a new result
  } status_t;

  // Midpoint of a search window, rounded down
  function automatic idx_t mid_of(idx_t lo, idx_t hi);
    idx_t diff;
    diff = hi - lo;
    return lo + (diff >> 1);
  endfunction

endpackage

// ===== design/lis_ctrl.sv =====
// Sequencing state machine for the LIS length tracker.
`timescale 1ns / 1ps

module lis_ctrl
  import lis_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // empty store: append without looking
          state_d = status_i.cnt_zero ? ST_UPDATE : ST_LAST_CMP;
        end
      end
      ST_LAST_CMP: begin
        if (status_i.gt_last) begin
          cmd_o.set_append = 1'b1;
          state_d = ST_UPDATE;
        end else begin
          cmd_o.start_search = 1'b1;
          // single tail: the window is already closed on entry zero
          state_d = status_i.cnt_one ? ST_UPDATE : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (status_i.search_done) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // hold until the result register frees up
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/lis_dpath.sv =====
// Tail store, binary search window, tail count and result register.
`timescale 1ns / 1ps

module lis_dpath
  import lis_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DATA_W-1:0] value_i,
  input  logic              last_item_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [LEN_W-1:0]  lis_length_o,
  output logic              overflow_o,
  output logic              sequence_done_o
);

  // Tail store, one read and one write port
  logic [DATA_W-1:0] mem_q [MAX_LEN];
  logic [DATA_W-1:0] rd_q;
  idx_t              rd_addr;
  idx_t              wr_addr;
  logic              wr_en;

  // Request and search state
  logic [DATA_W-1:0] key_q;
  logic              done_q;
  logic              append_q;
  idx_t              lo_q, hi_q, mid_q;
  idx_t              lo_nx, hi_nx;
  idx_t              last_idx;
  logic              probe_lt;

  // Sequence state
  cnt_t cnt_q;
  cnt_t cnt_new;
  logic room;
  logic overflow_q;

  // Result register
  logic             out_valid_q;
  logic [LEN_W-1:0] len_q;
  logic             ovf_out_q;
  logic             done_out_q;

  assign last_idx = IDX_W'(cnt_q - CNT_W'(1));
  assign room     = (cnt_q < CNT_W'(MAX_LEN));

  // Narrow the window by the probe at mid
  assign probe_lt = ($signed(rd_q) < $signed(key_q));
  assign lo_nx    = probe_lt ? mid_q + idx_t'(1) : lo_q;
  assign hi_nx    = probe_lt ? hi_q : mid_q;

  // Read address: last tail by default, else the next probe
  always_comb begin
    priority if (cmd_i.start_search) begin
      rd_addr = mid_of('0, last_idx);
    end else if (cmd_i.step) begin
      rd_addr = mid_of(lo_nx, hi_nx);
    end else begin
      rd_addr = last_idx;
    end
  end

  // Append at the end while there is room (no write when full), else replace at the search result
  assign wr_en   = cmd_i.update && (!append_q || room);
  assign wr_addr = append_q ? cnt_q[IDX_W-1:0] : lo_q;
  assign cnt_new = (append_q && room) ? cnt_q + CNT_W'(1) : cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= key_q;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Capture request, track search window
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= value_i;
      done_q <= last_item_i;
    end
    if (cmd_i.start_search) begin
      lo_q  <= '0;
      hi_q  <= last_idx;
      mid_q <= rd_addr;
    end else if (cmd_i.step) begin
      lo_q  <= lo_nx;
      hi_q  <= hi_nx;
      mid_q <= rd_addr;
    end
  end

  // Control: append flag, tail count, sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      append_q   <= 1'b0;
      cnt_q      <= '0;
      overflow_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        append_q <= (cnt_q == '0);
      end else if (cmd_i.set_append) begin
        append_q <= 1'b1;
      end
      if (cmd_i.update) begin
        cnt_q <= done_q ? '0 : cnt_new;
        if (append_q && !room) begin
          overflow_q <= 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      len_q      <= LEN_W'(cnt_new);
      ovf_out_q  <= overflow_q || (append_q && !room);
      done_out_q <= done_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lis_length_o    = len_q;
  assign overflow_o      = ovf_out_q;
  assign sequence_done_o = done_out_q;

  assign status_o.cnt_zero    = (cnt_q == '0);
  assign status_o.cnt_one     = (cnt_q == CNT_W'(1));
  assign status_o.gt_last     = ($signed(key_q) > $signed(rd_q));
  assign status_o.search_done = (lo_nx == hi_nx);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  // Tail count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(MAX_LEN))
    else $error("tail count beyond store depth");

  // A search probe always sits in an open window
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.step |-> (lo_q < hi_q))
    else $error("search probe in a closed window");

  // Overflow stays set once seen
  assert property (@(posedge clk_i) disable iff (!rst_ni) overflow_q |=> overflow_q)
    else $error("overflow flag dropped");

  // The end of a sequence empties the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd_i.update && done_q) |=> (cnt_q == '0))
    else $error("tail count not cleared at end of sequence");

  // A result is only loaded into a free result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.update |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

// ===== design/lis_length_tracker_top.sv =====
// Flow: a request goes from ST_IDLE straight to ST_UPDATE on an empty store, through ST_LAST_CMP
// to ST_UPDATE on an append past the last tail, else through ST_LAST_CMP and, with more than one
// tail, ST_SEARCH, one binary search probe per cycle, to ST_UPDATE. Requests are taken one at a
// time: in_ready is high only in ST_IDLE, so a new request waits until the last one is through;
// a result left waiting holds its request in ST_UPDATE until the result register frees up.
// Reset: tail count, overflow flag, state and result valid clear at once; the tail memory is
// not cleared and needs no clearing pass, entries are written before they are read.
`timescale 1ns / 1ps

module lis_length_tracker_top
  import lis_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] value_i,
  input  logic              last_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [LEN_W-1:0]  lis_length_o,
  output logic              overflow_o,
  output logic              sequence_done_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  lis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Tail store and result path
  lis_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .value_i         (value_i),
    .last_item_i     (last_item_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .lis_length_o    (lis_length_o),
    .overflow_o      (overflow_o),
    .sequence_done_o (sequence_done_o)
  );

endmodule

// ===== tb/lis_length_tracker_top_test.sv =====
// Self-checking testbench for the LIS length tracker: directed table, random sequences, overflow run.
`timescale 1ns / 1ps

module lis_length_tracker_top_test;
  import lis_pkg::*;

  localparam int     WATCHDOG_LIMIT = 3000;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     HOLD_AFTER     = 150;
  localparam int     RAMP_ITEMS     = MAX_LEN + 16;
  localparam longint RAMP_STEP      = 4000000;
  localparam longint VAL_MIN        = -(longint'(1) << (DATA_W - 1));
  localparam int     N_DIRECTED     = 21;

  // One result as the block reports it
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ovf;
    logic             done;
  } lis_res_t;

  // Directed row: request fields plus an optional hand-written result
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              typed;
    lis_res_t          res;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [DATA_W-1:0] value_i;
  logic              last_item_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [LEN_W-1:0]  lis_length_o;
  logic              overflow_o;
  logic              sequence_done_o;

  // Predictor state: smallest tails, tail count, sticky overflow
  logic signed [DATA_W-1:0] tails [MAX_LEN];
  int                       tail_cnt;
  logic                     ovf_seen;

  lis_res_t pending_results [$];
  int       mismatch_cnt = 0;
  int       sent_cnt;
  int       got_cnt = 0;
  int       idle_cycles = 0;
  int       send_burst_left;
  logic     send_no_idle;
  logic signed [DATA_W-1:0] walk_val;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{32'h8000_0000, 1'b0, 1'b1, '{11'd1, 1'b0, 1'b0}}, // smallest value into empty store
    '{32'h7FFF_FFFF, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}}, // largest value appends
    '{32'h7FFF_FFFF, 1'b0, 1'b1, '{11'd2, 1'b0, 1'b0}}, // equal to last tail: no growth
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'h8000_0000, 1'b0, 1'b0, '0},                   // equal to first tail
    '{32'h0000_0001, 1'b1, 1'b0, '0},                   // sequence ends on an append
    '{32'h0000_0000, 1'b1, 1'b1, '{11'd1, 1'b0, 1'b1}}, // one-element sequence
    '{32'd5,         1'b0, 1'b0, '0},
    '{32'd4,         1'b0, 1'b0, '0},
    '{32'd3,         1'b0, 1'b0, '0},
    '{32'd3,         1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h5555_5555, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFE, 1'b0, 1'b0, '0},
    '{32'h8000_0001, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, '0},
    '{32'd100,       1'b1, 1'b0, '0},
    '{32'd7,         1'b0, 1'b0, '0},
    '{32'd7,         1'b0, 1'b0, '0},
    '{32'd7,         1'b1, 1'b0, '0}
  };

  lis_length_tracker_top uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .value_i,
    .last_item_i,
    .out_valid_o,
    .out_ready_i,
    .lis_length_o,
    .overflow_o,
    .sequence_done_o
  );

  // Generate the clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the tail store by one element and return the running length
  function automatic lis_res_t track_lis(input logic signed [DATA_W-1:0] v, input logic lst);
    int       lo;
    int       hi;
    int       mid;
    lis_res_t r;
    if (tail_cnt == 0 || v > tails[tail_cnt-1]) begin
      if (tail_cnt < MAX_LEN) begin
        tails[tail_cnt] = v;
        tail_cnt++;
      end else begin
        ovf_seen = 1'b1;
      end
    end else begin
      // Replace the first tail not less than the element
      lo = 0;
      hi = tail_cnt;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tails[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      tails[lo] = v;
    end
    r.len  = LEN_W'(tail_cnt);
    r.ovf  = ovf_seen;
    r.done = lst;
    if (lst) tail_cnt = 0;
    return r;
  endfunction

  // Offer one request after a random gap, then record what it should produce
  task automatic send_req(input logic [DATA_W-1:0] v, input logic lst, input logic typed,
                          input lis_res_t typed_res);
    lis_res_t predicted;
    int       gap;
    if (send_burst_left == 0) begin
      send_no_idle    = ($urandom_range(0, 3) == 0);
      send_burst_left = $urandom_range(20, 80);
    end
    send_burst_left--;
    gap = send_no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    value_i     <= v;
    last_item_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = track_lis(v, lst);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    sent_cnt++;
  endtask

  // Send one sequence of random shape; its final request always ends it
  task automatic send_random_seq();
    int                seq_len;
    logic [DATA_W-1:0] v;
    logic              lst;
    seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
    for (int i = 0; i < seq_len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = $urandom_range(0, 16) - 8;
        4, 5, 6:    v = $urandom;
        7, 8: begin
          walk_val = walk_val + $urandom_range(1, 1000);
          v = walk_val;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       v = {1'b1, {(DATA_W-1){1'b0}}};
            1:       v = {1'b0, {(DATA_W-1){1'b1}}};
            2:       v = '0;
            default: v = '1;
          endcase
        end
      endcase
      lst = (i == seq_len - 1) || ($urandom_range(0, 29) == 0);
      send_req(v, lst, 1'b0, '0);
    end
  endtask

  // Drive stimulus: directed table, random sequences, overflow run, random again
  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    value_i         <= '0;
    last_item_i     <= 1'b0;
    tail_cnt        = 0;
    ovf_seen        = 1'b0;
    sent_cnt        = 0;
    send_burst_left = 0;
    send_no_idle    = 1'b0;
    walk_val        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
               directed_rows[i].res);
    end

    while (sent_cnt < 500) send_random_seq();

    // Fill the store past its depth with a rising ramp, mixing in replacements
    for (int k = 0; k < RAMP_ITEMS; k++) begin
      if (k > 0 && $urandom_range(0, 15) == 0) begin
        send_req(DATA_W'(VAL_MIN + longint'($urandom) % (longint'(k) * RAMP_STEP)),
                 1'b0, 1'b0, '0);
      end
      send_req(DATA_W'(VAL_MIN + longint'(k) * RAMP_STEP + $urandom_range(0, RAMP_STEP - 1)),
               1'b0, 1'b0, '0);
    end
    send_req('0, 1'b1, 1'b0, '0);

    while (sent_cnt < 1950) send_random_seq();
    in_valid_i <= 1'b0;

    // Drain, then let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** lis_length_tracker_top: PASSED **");
    end else begin
      $display("** lis_length_tracker_top: FAILED **");
    end
    $finish;
  end

  // Take results after random stalls; hold off once for a long stretch
  initial begin : result_sink
    int   gap;
    int   burst_left;
    logic no_idle;
    logic hold_done;
    out_ready_i <= 1'b0;
    burst_left  = 0;
    no_idle     = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (burst_left == 0) begin
        no_idle    = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(20, 80);
      end
      burst_left--;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (!hold_done && got_cnt >= HOLD_AFTER) begin
        gap       = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    lis_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_cnt++;
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result: length %0d overflow %0b done %0b",
                   lis_length_o, overflow_o, sequence_done_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (lis_length_o !== want.len || overflow_o !== want.ovf ||
            sequence_done_o !== want.done) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("result %0d: length %0d/%0d overflow %0b/%0b done %0b/%0b (exp/got)",
                     got_cnt, want.len, lis_length_o, want.ovf, overflow_o,
                     want.done, sequence_done_o);
          end
        end
      end
    end
  end

  // Stop the run when neither side moves a request for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** lis_length_tracker_top: FAILED **");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
design/lis_pkg.sv
design/lis_ctrl.sv
design/lis_dpath.sv
design/lis_length_tracker_top.sv
tb/lis_length_tracker_top_test.sv
